// File: rtl/bad_pkg.sv
`default_nettype none

package bad_pkg;

    // Channel, sum, fraction, step, row, cell count and configuration widths.
    localparam int CH_W    = 8;
    localparam int SUM_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = 21;
    localparam int ROW_W   = 12;
    localparam int CELLS_W = 9;
    localparam int CFG_W   = 21;

    localparam logic [STEP_W-1:0] STEP_MIN = 21'd65536;
    localparam logic [STEP_W-1:0] STEP_MAX = 21'd1048576;
    localparam logic [ROW_W-1:0]  DEST_HEIGHT_LIMIT = 12'd2048;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_SOURCE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_DEST_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_DEST_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_SCALE_STEP   = 2'd3;

    // One divider step per quotient bit.
    localparam logic [3:0] DIV_LAST_STEP = 4'd15;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic out_load;
    } bad_cmd_t;

    typedef struct packed {
        logic emit;
        logic single;
        logic out_free;
    } bad_sts_t;

endpackage

`default_nettype wire

// File: rtl/bad_ctrl.sv
`default_nettype none

module bad_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  bad_pkg::bad_sts_t  sts,
    output bad_pkg::bad_cmd_t  cmd
);
    import bad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_EVAL,
        S_DIV,
        S_OUTW
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cnt_next = '0;
                if (!sts.emit)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.single)
                begin
                    state_next = S_OUTW;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST_STEP)
                begin
                    state_next = S_OUTW;
                end
            end
            S_OUTW:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cmd.capture  = (state_reg == S_IDLE) && in_valid;
    assign cmd.eval     = (state_reg == S_EVAL);
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.out_load = (state_reg == S_OUTW) && sts.out_free;

    // An item is evaluated after it was captured, with S_MUL between the two.
    a_eval_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> $past(cmd.capture, 2))
        else $error("evaluation without a captured item");

    // When the divider is used, it runs its full length before a result is loaded.
    a_div_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (state_next == S_OUTW) |-> (cnt_reg == DIV_LAST_STEP))
        else $error("divider left early");

endmodule

`default_nettype wire

// File: rtl/bad_dp.sv
`default_nettype none

module bad_dp #(
    parameter int MAX_DEST_WIDTH   = 2048,
    parameter int MAX_SOURCE_WIDTH = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [bad_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic [31:0]                 pixel_word,
    input  wire logic                        frame_start,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [31:0]                      out_pixel,
    output logic                             row_end,
    output logic                             frame_end,
    input  bad_pkg::bad_cmd_t                cmd,
    output bad_pkg::bad_sts_t                sts
);
    import bad_pkg::*;

    localparam int OCW  = $clog2(MAX_DEST_WIDTH + 1);
    localparam int AW   = $clog2(MAX_DEST_WIDTH);
    localparam int SCW  = $clog2(MAX_SOURCE_WIDTH);
    localparam int SWW  = SCW + 1;
    localparam int CPW  = OCW + STEP_W;
    localparam int EW   = CPW - FRAC_W;
    localparam int RPW  = ROW_W + STEP_W;
    localparam int YW   = RPW - FRAC_W;
    localparam int XW   = (EW > SWW) ? EW : SWW;
    localparam int MEMW = 3 * SUM_W;

    // Configuration registers.
    logic [12:0]       src_width_reg;
    logic [11:0]       dst_width_reg;
    logic [11:0]       dst_height_reg;
    logic [STEP_W-1:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 13'd256;
            dst_width_reg  <= 12'd128;
            dst_height_reg <= 12'd128;
            step_reg       <= 21'd131072;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH: src_width_reg  <= cfg_data[12:0];
                CFG_DEST_WIDTH:   dst_width_reg  <= cfg_data[11:0];
                CFG_DEST_HEIGHT:  dst_height_reg <= cfg_data[11:0];
                CFG_SCALE_STEP:   step_reg       <= cfg_data[STEP_W-1:0];
                default:          step_reg       <= step_reg;
            endcase
        end
    end

    // Registers are used clamped to their legal ranges.
    logic [SWW-1:0]    sw_c;
    logic [OCW-1:0]    dw_c;
    logic [ROW_W-1:0]  dh_c;
    logic [STEP_W-1:0] st_c;

    always_comb
    begin
        if (src_width_reg == 13'd0)
            sw_c = SWW'(1);
        else if (32'(src_width_reg) > 32'(MAX_SOURCE_WIDTH))
            sw_c = SWW'(MAX_SOURCE_WIDTH);
        else
            sw_c = SWW'(src_width_reg);

        if (dst_width_reg == 12'd0)
            dw_c = OCW'(1);
        else if (32'(dst_width_reg) > 32'(MAX_DEST_WIDTH))
            dw_c = OCW'(MAX_DEST_WIDTH);
        else
            dw_c = OCW'(dst_width_reg);

        if (dst_height_reg == 12'd0)
            dh_c = 12'd1;
        else if (dst_height_reg > DEST_HEIGHT_LIMIT)
            dh_c = DEST_HEIGHT_LIMIT;
        else
            dh_c = dst_height_reg;

        if (step_reg < STEP_MIN)
            st_c = STEP_MIN;
        else if (step_reg > STEP_MAX)
            st_c = STEP_MAX;
        else
            st_c = step_reg;
    end

    // Position counters.
    logic [SCW-1:0]   sc_reg;
    logic [ROW_W-1:0] sr_reg;
    logic [OCW-1:0]   oc_reg;
    logic [ROW_W-1:0] or_reg;
    logic [31:0]      pix_reg;

    // Edge products and the column sum read, registered before use.
    logic [CPW-1:0] xprod_reg;
    logic [RPW-1:0] yprod_reg;
    logic [MEMW-1:0] sum_rd_reg;
    logic [MEMW-1:0] col_mem [MAX_DEST_WIDTH];

    always_ff @(posedge clk)
    begin
        xprod_reg  <= CPW'(oc_reg) * CPW'(st_c);
        yprod_reg  <= RPW'(or_reg) * RPW'(st_c);
        sum_rd_reg <= col_mem[oc_reg[AW-1:0]];
    end

    logic [CPW-1:0] xprod2;
    logic [RPW-1:0] yprod2;
    logic [EW-1:0]  x1, x2;
    logic [YW-1:0]  y1, y2, srx;
    logic [XW-1:0]  scx, x1x, x2x;
    logic           in_box, first, col_last, row_last, line_end;
    logic [SWW-1:0] sc_inc;
    logic [4:0]     box_w, box_h;
    logic [9:0]     cells10;
    logic [CELLS_W-1:0] cells;
    logic [SUM_W-1:0] ch [3];
    logic [SUM_W-1:0] sum [3];
    logic           rend, fend;

    always_comb
    begin
        xprod2 = xprod_reg + CPW'(st_c);
        yprod2 = yprod_reg + RPW'(st_c);
        x1  = xprod_reg[CPW-1:FRAC_W];
        x2  = xprod2[CPW-1:FRAC_W];
        y1  = yprod_reg[RPW-1:FRAC_W];
        y2  = yprod2[RPW-1:FRAC_W];
        scx = XW'(sc_reg);
        x1x = XW'(x1);
        x2x = XW'(x2);
        srx = YW'(sr_reg);

        in_box = (oc_reg < dw_c) && (or_reg < dh_c) && (scx >= x1x) && (scx < x2x)
                 && (srx >= y1) && (srx < y2);
        first    = (srx == y1) && (scx == x1x);
        col_last = (scx == x2x - XW'(1));
        row_last = (srx == y2 - YW'(1));

        sc_inc   = SWW'(sc_reg) + SWW'(1);
        line_end = (sc_inc >= sw_c);

        box_w   = 5'(x2 - x1);
        box_h   = 5'(y2 - y1);
        cells10 = {5'd0, box_w} * {5'd0, box_h};
        cells   = cells10[CELLS_W-1:0];

        ch[0] = SUM_W'(pix_reg[23:16]);
        ch[1] = SUM_W'(pix_reg[15:8]);
        ch[2] = SUM_W'(pix_reg[7:0]);
        for (int i = 0; i < 3; i++)
        begin
            if (first)
                sum[i] = ch[i];
            else
                sum[i] = sum_rd_reg[(2-i)*SUM_W +: SUM_W] + ch[i];
        end

        rend = (oc_reg == dw_c - OCW'(1));
        fend = rend && (or_reg == dh_c - 12'd1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && in_box)
        begin
            col_mem[oc_reg[AW-1:0]] <= {sum[0], sum[1], sum[2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
            sr_reg <= '0;
            oc_reg <= '0;
            or_reg <= '0;
        end
        else if (cmd.capture)
        begin
            if (frame_start)
            begin
                sc_reg <= '0;
                sr_reg <= '0;
                oc_reg <= '0;
                or_reg <= '0;
            end
        end
        else if (cmd.eval)
        begin
            if (line_end)
            begin
                if ((or_reg < dh_c) && row_last)
                    or_reg <= or_reg + 12'd1;
                sc_reg <= '0;
                sr_reg <= sr_reg + 12'd1;
                oc_reg <= '0;
            end
            else
            begin
                sc_reg <= sc_reg + SCW'(1);
                if (in_box && col_last)
                    oc_reg <= oc_reg + OCW'(1);
            end
        end
    end

    // Three restoring divider lanes, one quotient bit per cycle.
    logic [SUM_W-1:0]   quo_reg [3];
    logic [CELLS_W-1:0] rem_reg [3];
    logic [CELLS_W-1:0] cells_reg;
    logic               single_reg, rend_reg, fend_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= pixel_word;
        end
        if (cmd.eval)
        begin
            cells_reg  <= cells;
            single_reg <= (cells == CELLS_W'(1));
            rend_reg   <= rend;
            fend_reg   <= fend;
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        logic [CELLS_W:0] rem_sh;
        assign rem_sh = {rem_reg[g], quo_reg[g][SUM_W-1]};

        always_ff @(posedge clk)
        begin
            if (cmd.eval)
            begin
                quo_reg[g] <= sum[g];
                rem_reg[g] <= '0;
            end
            else if (cmd.div_step)
            begin
                if (rem_sh >= {1'b0, cells_reg})
                begin
                    rem_reg[g] <= CELLS_W'(rem_sh - {1'b0, cells_reg});
                    quo_reg[g] <= {quo_reg[g][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g] <= rem_sh[CELLS_W-1:0];
                    quo_reg[g] <= {quo_reg[g][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Output register.
    logic        out_valid_reg;
    logic [31:0] out_pixel_reg;
    logic        row_end_reg, frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (single_reg)
                out_pixel_reg <= pix_reg;
            else
                out_pixel_reg <= {8'd0, quo_reg[0][CH_W-1:0], quo_reg[1][CH_W-1:0],
                                  quo_reg[2][CH_W-1:0]};
            row_end_reg   <= rend_reg;
            frame_end_reg <= fend_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign row_end      = row_end_reg;
    assign frame_end    = frame_end_reg;
    assign sts.emit     = in_box && col_last && row_last;
    assign sts.single   = (cells == CELLS_W'(1));
    assign sts.out_free = !out_valid_reg || !out_stall;

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    // An emitted box never has zero cells.
    a_cells_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && sts.emit |-> (cells != '0))
        else $error("empty box emitted");

endmodule

`default_nettype wire

// File: rtl/box_average_downscaler.sv
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_we               cfg_index, cfg_data
// in       in         in_valid / in_stall  pixel_word, frame_start
// out      out        out_valid / out_stall out_pixel, row_end, frame_end
//
// An item passes capture, S_MUL and S_EVAL; one that closes a one-pixel box then
// goes to S_OUTW, and one that closes a larger box goes through the three-lane
// restoring divider first; either may wait for the output register to free up.
// A finished result sits in the output register while the next item is taken.
// rst_n sets counters, control state, out_valid and config registers to defaults.
// The column sum memory is not cleared; the first pixel of a box overwrites it.
`default_nettype none

module box_average_downscaler #(
    parameter int MAX_DEST_WIDTH   = 2048,
    parameter int MAX_SOURCE_WIDTH = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [bad_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [31:0]                pixel_word,
    input  wire logic                       frame_start,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [31:0]                     out_pixel,
    output logic                            row_end,
    output logic                            frame_end
);
    import bad_pkg::*;

    bad_cmd_t cmd;
    bad_sts_t sts;

    bad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bad_dp #(
        .MAX_DEST_WIDTH   (MAX_DEST_WIDTH),
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_word  (pixel_word),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_pixel   (out_pixel),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_box_average_downscaler.sv
`timescale 1ns / 1ps

module tb_box_average_downscaler;

    import bad_pkg::*;

    typedef struct {
        logic [31:0] pixel;
        logic        row_end;
        logic        frame_end;
    } result_t;

    typedef struct {
        logic [31:0] pixel;
        logic        frame_start;
    } source_item_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [31:0]       pixel_word;
    logic              frame_start;
    logic              out_valid;
    logic              out_stall;
    logic [31:0]       out_pixel;
    logic              row_end;
    logic              frame_end;

    box_average_downscaler uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .pixel_word(pixel_word), .frame_start(frame_start),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_pixel(out_pixel), .row_end(row_end), .frame_end(frame_end)
    );

    // Shadow registers, raw as written.
    logic [12:0] reg_source_width;
    logic [11:0] reg_dest_width;
    logic [11:0] reg_dest_height;
    logic [20:0] reg_scale_step;

    // Shadow of the scaler state.
    logic [47:0]  sums_by_column [0:2047];
    int unsigned  src_col, out_col, out_row;
    logic [11:0]  src_row;

    source_item_t pending_pixels[$];
    result_t      expected_pixels[$];
    int           mismatches;
    int           accepted_pixels;
    int           idle_cycles;

    always #4 clk = ~clk;

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned box_edge(int unsigned n, int unsigned step);
        longint unsigned p;
        p = longint'(n) * longint'(step);
        return int'(p >> 16);
    endfunction

    task automatic predict_downscale(input logic [31:0] pix, input logic fs);
        int unsigned sw, dw, dh, st, x1, x2, y1, y2, sc, sr, cells;
        logic [47:0] chan, total;
        logic [15:0] r, g, b;
        result_t res;
        sw = clamp(reg_source_width, 1, 4096);
        dw = clamp(reg_dest_width, 1, 2048);
        dh = clamp(reg_dest_height, 1, 2048);
        st = clamp(reg_scale_step, STEP_MIN, STEP_MAX);
        if (fs)
        begin
            src_col = 0;
            src_row = '0;
            out_col = 0;
            out_row = 0;
        end
        sc = src_col;
        sr = src_row;
        x1 = box_edge(out_col, st);
        x2 = box_edge(out_col + 1, st);
        y1 = box_edge(out_row, st);
        y2 = box_edge(out_row + 1, st);
        if (out_col < dw && out_row < dh && sc >= x1 && sc < x2 && sr >= y1 && sr < y2)
        begin
            chan = {8'd0, pix[23:16], 8'd0, pix[15:8], 8'd0, pix[7:0]};
            if (sr == y1 && sc == x1)
                total = chan;
            else
            begin
                total[47:32] = sums_by_column[out_col][47:32] + chan[47:32];
                total[31:16] = sums_by_column[out_col][31:16] + chan[31:16];
                total[15:0]  = sums_by_column[out_col][15:0] + chan[15:0];
            end
            sums_by_column[out_col] = total;
            if (sc == x2 - 1)
            begin
                if (sr == y2 - 1)
                begin
                    cells = (x2 - x1) * (y2 - y1);
                    if (cells == 1)
                        res.pixel = pix;
                    else
                    begin
                        r = 16'(total[47:32] / cells);
                        g = 16'(total[31:16] / cells);
                        b = 16'(total[15:0] / cells);
                        res.pixel = {8'd0, r[7:0], g[7:0], b[7:0]};
                    end
                    res.row_end = (out_col == dw - 1);
                    res.frame_end = res.row_end && (out_row == dh - 1);
                    expected_pixels.push_back(res);
                end
                out_col++;
            end
        end
        if (sc + 1 >= sw)
        begin
            if (out_row < dh && sr == y2 - 1)
                out_row++;
            src_col = 0;
            src_row = sr[11:0] + 12'd1;
            out_col = 0;
        end
        else
            src_col = sc + 1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Idle chances in percent, by how far the run has come.
    function automatic int sender_idle_pct();
        if (accepted_pixels < 150) return 36;
        if (accepted_pixels < 300) return 71;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted_pixels < 150) return 71;
        if (accepted_pixels < 300) return 36;
        return 0;
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        logic         next_valid;
        source_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel_word <= '0;
            frame_start <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                predict_downscale(pixel_word, frame_start);
                accepted_pixels++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_pixels.size() != 0
                && $urandom_range(99, 0) >= sender_idle_pct())
            begin
                item = pending_pixels.pop_front();
                pixel_word <= item.pixel;
                frame_start <= item.frame_start;
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
        end
    end

    // Monitor.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected item", out_pixel, '0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_pixel !== want.pixel)
                        report_mismatch("out_pixel", out_pixel, want.pixel);
                    if (row_end !== want.row_end)
                        report_mismatch("row_end", 32'(row_end), 32'(want.row_end));
                    if (frame_end !== want.frame_end)
                        report_mismatch("frame_end", 32'(frame_end), 32'(want.frame_end));
                end
            end
            out_stall <= ($urandom_range(99, 0) < receiver_idle_pct());
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_SOURCE_WIDTH: reg_source_width = value[12:0];
            CFG_DEST_WIDTH:   reg_dest_width = value[11:0];
            CFG_DEST_HEIGHT:  reg_dest_height = value[11:0];
            CFG_SCALE_STEP:   reg_scale_step = value[20:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
        // A dropped pixel may still be in flight.
        repeat (40) @(posedge clk);
    endtask

    // Fill: 0 random, 1 all ones, 2 frames alternating all ones and all zeros.
    task automatic queue_frames(input int frames, input int rows, input int cols,
                                input int fill, input int noise_pct);
        source_item_t item;
        for (int f = 0; f < frames; f++)
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < cols; c++)
                begin
                    case (fill)
                        1: item.pixel = '1;
                        2: item.pixel = f[0] ? 32'd0 : 32'hFFFF_FFFF;
                        default: item.pixel = $urandom;
                    endcase
                    item.frame_start = (r == 0 && c == 0) ||
                                       ($urandom_range(99, 0) < noise_pct);
                    pending_pixels.push_back(item);
                end
    endtask

    task automatic run_setting(input logic [12:0] sw, input logic [11:0] dw,
                               input logic [11:0] dh, input logic [20:0] step,
                               input int frames, input int rows, input int cols,
                               input int fill, input int noise_pct);
        wait_drained();
        write_reg(CFG_SOURCE_WIDTH, CFG_W'(sw));
        write_reg(CFG_DEST_WIDTH, CFG_W'(dw));
        write_reg(CFG_DEST_HEIGHT, CFG_W'(dh));
        write_reg(CFG_SCALE_STEP, step);
        queue_frames(frames, rows, cols, fill, noise_pct);
    endtask

    initial
    begin
        int unsigned sw, dw, dh, step, rows;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SOURCE_WIDTH;
        cfg_data = '0;
        mismatches = 0;
        accepted_pixels = 0;
        idle_cycles = 0;
        reg_source_width = 13'd256;
        reg_dest_width = 12'd128;
        reg_dest_height = 12'd128;
        reg_scale_step = 21'd131072;
        src_col = 0;
        src_row = '0;
        out_col = 0;
        out_row = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // One-pixel boxes pass the whole word, all ones then all zeros.
        run_setting(13'd4, 12'd4, 12'd2, 21'd65536, 2, 2, 4, 2, 0);
        // Registers at zero are used as the smallest settings.
        run_setting(13'd0, 12'd0, 12'd0, 21'd0, 1, 3, 1, 0, 0);
        // Width and height registers at all ones; a partial row, then the tail of it is cut off.
        run_setting(13'h1FFF, 12'hFFF, 12'hFFF, 21'd98304, 1, 1, 20, 0, 0);
        // Tail columns and rows beyond the last box are dropped.
        run_setting(13'd7, 12'd4, 12'd3, 21'd98304, 1, 6, 7, 0, 0);
        // Largest box: 16 by 16 pixels of full channels.
        run_setting(13'd16, 12'd1, 12'd1, 21'h1FFFFF, 1, 16, 16, 1, 0);

        while (accepted_pixels + pending_pixels.size() < 400)
        begin
            sw = $urandom_range(12, 1);
            dw = $urandom_range(8, 1);
            dh = $urandom_range(4, 1);
            step = $urandom_range(262144, 65536);
            rows = ((dh * step) >> 16) + $urandom_range(1, 0);
            run_setting(13'(sw), 12'(dw), 12'(dh), 21'(step), $urandom_range(3, 1),
                        rows, sw, 0, $urandom_range(99, 0) < 25 ? 3 : 0);
        end
        wait_drained();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
